// ----- hw/rtl/moisture_average_and_scale_defines.svh -----
// Assertion macros shared by the moisture averaging checker.
`ifndef MOISTURE_AVERAGE_AND_SCALE_DEFINES_SVH
`define MOISTURE_AVERAGE_AND_SCALE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define MAS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define MAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/mas_pkg.sv -----
// Shared types and constants of the moisture averaging and scaling block.
package mas_pkg;

	// Result width and full scale of the Q7.8 moisture percentage (100 % * 256).
	localparam int unsigned Q8_W = 15;
	localparam logic [Q8_W-1:0] FULL_SCALE_Q8 = 15'd25600;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRY_COUNT   = 2'd0,
		REG_WET_COUNT   = 2'd1,
		REG_LOW_LIMIT   = 2'd2,
		REG_HIGH_LIMIT  = 2'd3
	} cfg_reg_t;

	// Register values after reset, cut to the converter width where they are used.
	localparam int unsigned DRY_RESET  = 3000;
	localparam int unsigned WET_RESET  = 1200;
	localparam int unsigned LOW_RESET  = 10;
	localparam int unsigned HIGH_RESET = 4085;

endpackage

// ----- hw/rtl/moisture_average_and_scale.sv -----
// Top level of the moisture averaging and scaling block.
//
//   Channel   Signals                                         Direction
//   input     in_valid, in_stall, adc_sample                  sample in
//   output    out_valid, out_stall, average_raw, moisture_q8,  reading out
//             reading_valid
//   config    cfg_we, cfg_index, cfg_wdata                    register write
//
// A sample that does not close a group is accumulated; the next one may follow
// at once. The sample that closes a group keeps in_stall high while the sequencer
// runs: the mean (a multiply by the reciprocal of the group size), the limit
// checks, the multiply and DVD_W steps of the shared restoring divider for the
// percentage, then the handover of the result to the output register once that
// register is empty or being drained. The multiply and divider are skipped when
// the percentage is known to be zero.
// Reset clears the running sum, the count, the sequencer and the output valid
// and loads the default register values. A stalled result sits in the output
// register while new samples keep coming; only a second finished reading waits.
module moisture_average_and_scale #(
	parameter int SAMPLES_PER_READING = 8,
	parameter int ADC_BITS            = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Sample channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ADC_BITS-1:0]                adc_sample,
	// Reading channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ADC_BITS-1:0]                average_raw,
	output logic [mas_pkg::Q8_W-1:0]           moisture_q8,
	output logic                               reading_valid,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [mas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ADC_BITS-1:0]                cfg_wdata
);

	localparam int CNT_W  = $clog2(SAMPLES_PER_READING);
	localparam int SUM_W  = ADC_BITS + $clog2(SAMPLES_PER_READING);
	// The dividend register also holds the group sum while the mean is formed.
	localparam int DVD_W  = ADC_BITS + mas_pkg::Q8_W;
	localparam int DVS_W  = ADC_BITS;
	localparam int STEP_W = $clog2(DVD_W + 1);
	localparam int DIFF_W = ADC_BITS + 1;
	// The mean is the sum times ceil(2^MEAN_SHIFT / group size), shifted down by
	// MEAN_SHIFT. With the shift SUM_W plus the bits of the group size, the
	// truncated quotient is exact for every sum that fits SUM_W bits.
	localparam int MEAN_SHIFT = SUM_W + CNT_W;
	localparam int MUL_W      = SUM_W + 2;
	localparam int PROD_W     = SUM_W + MUL_W;
	localparam logic [MUL_W-1:0] MEAN_MUL = MUL_W'(((64'd1 << MEAN_SHIFT) +
		64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_CHECK,
		ST_MUL,
		ST_DIV_PCT,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [SUM_W-1:0]           sum_q;
	logic [CNT_W-1:0]           count_q;
	logic [ADC_BITS-1:0]        dry_q, wet_q, low_q, high_q;

	// Shared divider: remainder, quotient/dividend shift register, divisor, step count.
	logic [DVS_W-1:0]           rem_q;
	logic [DVD_W-1:0]           quo_q;
	logic [DVS_W-1:0]           divisor_q;
	logic [STEP_W-1:0]          step_q;

	logic [ADC_BITS-1:0]        avg_q;
	logic                       valid_q;
	logic [ADC_BITS-1:0]        num_mag_q;
	logic [ADC_BITS-1:0]        den_mag_q;
	logic [mas_pkg::Q8_W-1:0]   pct_q;

	logic                       out_valid_q;
	logic [ADC_BITS-1:0]        out_avg_q;
	logic [mas_pkg::Q8_W-1:0]   out_pct_q;
	logic                       out_rv_q;

	logic [SUM_W-1:0]           sum_next;
	logic                       in_xfer;
	logic                       group_end;
	logic [PROD_W-1:0]          mean_prod;
	logic [ADC_BITS-1:0]        mean_val;
	logic [DVS_W:0]             rem_shift;
	logic [DVS_W:0]             rem_sub;
	logic                       rem_ge;
	logic [DVS_W-1:0]           rem_next;
	logic [DVD_W-1:0]           quo_next;
	logic                       avg_in_range;
	logic signed [DIFF_W-1:0]   num_diff;
	logic signed [DIFF_W-1:0]   den_diff;
	logic [DIFF_W-1:0]          num_abs;
	logic [DIFF_W-1:0]          den_abs;
	logic                       pct_zero;
	logic [mas_pkg::Q8_W-1:0]   pct_clamped;
	logic                       out_free;
	logic                       out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign sum_next  = sum_q + SUM_W'(adc_sample);
	assign group_end = (count_q == CNT_W'(SAMPLES_PER_READING - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_DONE) && out_free;

	// Truncated mean of the group sum held in the dividend register.
	assign mean_prod = PROD_W'(quo_q[SUM_W-1:0]) * PROD_W'(MEAN_MUL);
	assign mean_val  = mean_prod[MEAN_SHIFT +: ADC_BITS];

	// One restoring step: shift in the next dividend bit and subtract when it fits.
	assign rem_shift = {rem_q, quo_q[DVD_W-1]};
	assign rem_sub   = rem_shift - {1'b0, divisor_q};
	assign rem_ge    = (rem_shift >= {1'b0, divisor_q});
	assign rem_next  = rem_ge ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
	assign quo_next  = {quo_q[DVD_W-2:0], rem_ge};

	// Limit checks and signed differences of the finished mean.
	assign avg_in_range = (avg_q > low_q) && (avg_q < high_q);
	assign num_diff     = $signed({1'b0, dry_q}) - $signed({1'b0, avg_q});
	assign den_diff     = $signed({1'b0, dry_q}) - $signed({1'b0, wet_q});
	assign num_abs      = num_diff[DIFF_W-1] ? DIFF_W'(-num_diff) : DIFF_W'(num_diff);
	assign den_abs      = den_diff[DIFF_W-1] ? DIFF_W'(-den_diff) : DIFF_W'(den_diff);
	// The percentage is zero when the reading is invalid, the two calibration
	// counts are equal, or the quotient would come out negative.
	assign pct_zero = !avg_in_range || (den_diff == '0) ||
		(num_diff[DIFF_W-1] != den_diff[DIFF_W-1]);

	// Clamp the final quotient to 100 %.
	assign pct_clamped = (quo_next > DVD_W'(mas_pkg::FULL_SCALE_Q8)) ?
		mas_pkg::FULL_SCALE_Q8 : quo_next[mas_pkg::Q8_W-1:0];

	// Configuration registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_q  <= ADC_BITS'(mas_pkg::DRY_RESET);
			wet_q  <= ADC_BITS'(mas_pkg::WET_RESET);
			low_q  <= ADC_BITS'(mas_pkg::LOW_RESET);
			high_q <= ADC_BITS'(mas_pkg::HIGH_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				mas_pkg::REG_DRY_COUNT:  dry_q  <= cfg_wdata;
				mas_pkg::REG_WET_COUNT:  wet_q  <= cfg_wdata;
				mas_pkg::REG_LOW_LIMIT:  low_q  <= cfg_wdata;
				mas_pkg::REG_HIGH_LIMIT: high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer, accumulator, shared divider and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register takes a finished reading once it is empty or
			// being drained, and otherwise empties when its reading is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_avg_q   <= avg_q;
				out_pct_q   <= pct_q;
				out_rv_q    <= valid_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (group_end) begin
							// Group complete: park the sum for the mean.
							sum_q   <= '0;
							count_q <= '0;
							quo_q   <= DVD_W'(sum_next);
							state_q <= ST_MEAN;
						end else begin
							sum_q   <= sum_next;
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_MEAN: begin
					avg_q   <= mean_val;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					valid_q   <= avg_in_range;
					num_mag_q <= num_abs[ADC_BITS-1:0];
					den_mag_q <= den_abs[ADC_BITS-1:0];
					if (pct_zero) begin
						pct_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					quo_q     <= DVD_W'(num_mag_q) * DVD_W'(mas_pkg::FULL_SCALE_Q8);
					rem_q     <= '0;
					divisor_q <= den_mag_q;
					step_q    <= STEP_W'(DVD_W);
					state_q   <= ST_DIV_PCT;
				end
				ST_DIV_PCT: begin
					rem_q  <= rem_next;
					quo_q  <= quo_next;
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						pct_q   <= pct_clamped;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hand over once the output register is empty or being drained.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign average_raw   = out_avg_q;
	assign moisture_q8   = out_pct_q;
	assign reading_valid = out_rv_q;

endmodule

// ----- hw/rtl/mas_checker.sv -----
// Port-level assertions for the moisture averaging block and their bind.
`include "moisture_average_and_scale_defines.svh"

module mas_checker #(
	parameter int ADC_BITS = 12
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ADC_BITS-1:0]           average_raw,
	input logic [mas_pkg::Q8_W-1:0]      moisture_q8,
	input logic                          reading_valid
);

	// The percentage never exceeds full scale.
	`MAS_ASSERT_NOW(a_pct_max, out_valid, moisture_q8 <= mas_pkg::FULL_SCALE_Q8, "moisture above 100 percent")

	// An invalid reading always reports zero moisture.
	`MAS_ASSERT_NOW(a_invalid_zero, out_valid && !reading_valid, moisture_q8 == '0, "invalid reading with nonzero moisture")

	// A new reading only appears after the sample side was held off for the computation.
	`MAS_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(in_stall), "reading appeared without a busy period")

	// A stalled reading stays put.
	`MAS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(average_raw) && $stable(moisture_q8) && $stable(reading_valid), "stalled reading changed")

endmodule

bind moisture_average_and_scale mas_checker #(
	.ADC_BITS(ADC_BITS)
) u_mas_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.average_raw   (average_raw),
	.moisture_q8   (moisture_q8),
	.reading_valid (reading_valid)
);

// ----- tb/sv/tb_moisture_average_and_scale.sv -----
// Self-checking testbench for the moisture averaging and scaling block.
module tb_moisture_average_and_scale;

	localparam int ADC_BITS = 12;
	localparam int GROUP_SIZE = 8;
	localparam int ADC_MAX = (1 << ADC_BITS) - 1;
	// The slowest reading keeps the sample side stalled through the whole divider
	// run; this leaves a wide margin.
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PERCENT = 12;

	typedef logic [ADC_BITS-1:0] count_t;

	// One reading as the block should report it.
	typedef struct packed {
		count_t average;
		logic [mas_pkg::Q8_W-1:0] moisture;
		logic in_range;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	count_t adc_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	count_t average_raw;
	logic [mas_pkg::Q8_W-1:0] moisture_q8;
	logic reading_valid;
	logic cfg_we = 1'b0;
	mas_pkg::cfg_reg_t cfg_index = mas_pkg::REG_DRY_COUNT;
	count_t cfg_wdata = '0;

	// Shadow copy of the calibration registers, loaded with the reset values.
	count_t cal_dry = count_t'(mas_pkg::DRY_RESET);
	count_t cal_wet = count_t'(mas_pkg::WET_RESET);
	count_t lim_low = count_t'(mas_pkg::LOW_RESET);
	count_t lim_high = count_t'(mas_pkg::HIGH_RESET);

	// Running group of samples, as the block accumulates it.
	int group_sum = 0;
	int group_fill = 0;

	// Readings predicted but not yet seen on the output, oldest first.
	reading_t readings_due[$];

	int mismatches = 0;
	int cycle_count = 0;
	bit sender_gaps = 1'b1;
	bit reader_stalls = 1'b1;

	moisture_average_and_scale #(
		.SAMPLES_PER_READING(GROUP_SIZE),
		.ADC_BITS(ADC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.average_raw(average_raw),
		.moisture_q8(moisture_q8),
		.reading_valid(reading_valid),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock with a period of 8 time units.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The run is cut off here if the block hangs or a reading never arrives.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("moisture_average_and_scale test failed");
			$finish;
		end
	end

	// The reading side holds off the block at random whenever stalls are enabled.
	always @(posedge clk) begin
		out_stall <= reader_stalls && arst_n && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Linear map from the dry count (0 %) to the wet count (100 %) in Q7.8. The
	// signed quotient truncates toward zero before the clamp, so a wet count above
	// the dry count simply flips the sign of both differences. Equal counts have
	// no slope and read as zero.
	function automatic logic [mas_pkg::Q8_W-1:0] percent_q8(input count_t average);
		longint span;
		longint scaled;
		longint quotient;
		span = longint'(cal_dry) - longint'(cal_wet);
		if (span == 0)
			return '0;
		scaled = (longint'(cal_dry) - longint'(average)) * longint'(mas_pkg::FULL_SCALE_Q8);
		quotient = scaled / span;
		if (quotient < 0)
			quotient = 0;
		if (quotient > longint'(mas_pkg::FULL_SCALE_Q8))
			quotient = longint'(mas_pkg::FULL_SCALE_Q8);
		return quotient[mas_pkg::Q8_W-1:0];
	endfunction

	// Adds one accepted sample to the group; the eighth sample closes the group
	// and queues the reading that it should produce.
	task automatic absorb_sample(input count_t sample);
		count_t average;
		reading_t due;
		group_sum += int'(sample);
		group_fill++;
		if (group_fill == GROUP_SIZE) begin
			average = count_t'(group_sum / GROUP_SIZE);
			due.average = average;
			due.in_range = (average > lim_low) && (average < lim_high);
			due.moisture = due.in_range ? percent_q8(average) : '0;
			readings_due.push_back(due);
			group_sum = 0;
			group_fill = 0;
		end
	endtask

	// Every sample transfer feeds the prediction at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			absorb_sample(adc_sample);
	end

	// Every reading transfer is compared field by field with the oldest prediction.
	always @(posedge clk) begin : check_readings
		reading_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (readings_due.size() == 0) begin
				$display("%0t: unexpected reading: average %0d, moisture %0d, valid %0b",
					$time, average_raw, moisture_q8, reading_valid);
				mismatches++;
			end else begin
				due = readings_due.pop_front();
				if (average_raw !== due.average) begin
					$display("%0t: average_raw expected %0d, actual %0d",
						$time, due.average, average_raw);
					mismatches++;
				end
				if (moisture_q8 !== due.moisture) begin
					$display("%0t: moisture_q8 expected %0d, actual %0d (average %0d)",
						$time, due.moisture, moisture_q8, due.average);
					mismatches++;
				end
				if (reading_valid !== due.in_range) begin
					$display("%0t: reading_valid expected %0b, actual %0b (average %0d)",
						$time, due.in_range, reading_valid, due.average);
					mismatches++;
				end
			end
		end
	end

	// Offers one sample, after a random gap when gaps are enabled, and returns at
	// the edge that accepts it. The valid stays high so that a following sample
	// can go out in the very next cycle.
	task automatic send_sample(input count_t value);
		while (sender_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drops the valid and waits until every predicted reading has come out, then
	// lets the block finish any work that produces no reading.
	task automatic settle_readings();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (readings_due.size() != 0);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// One register write; the enable is left high for a following write.
	task automatic write_reg(input mas_pkg::cfg_reg_t index, input count_t value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		case (index)
			mas_pkg::REG_DRY_COUNT: cal_dry = value;
			mas_pkg::REG_WET_COUNT: cal_wet = value;
			mas_pkg::REG_LOW_LIMIT: lim_low = value;
			mas_pkg::REG_HIGH_LIMIT: lim_high = value;
			default: ;
		endcase
	endtask

	// Writes all four calibration registers; only called while the block is idle.
	task automatic load_calibration(input count_t dry, input count_t wet,
			input count_t low, input count_t high);
		write_reg(mas_pkg::REG_DRY_COUNT, dry);
		write_reg(mas_pkg::REG_WET_COUNT, wet);
		write_reg(mas_pkg::REG_LOW_LIMIT, low);
		write_reg(mas_pkg::REG_HIGH_LIMIT, high);
		cfg_we <= 1'b0;
	endtask

	// Random samples grouped around a point of interest. Each run of eight shares
	// a center near one of the calibration points or anywhere in range, and a
	// spread that is often zero so that the average lands exactly on a limit, the
	// dry count or the wet count. A few samples are noise or full-scale extremes.
	task automatic run_samples(input int count);
		int center;
		int spread;
		int value;
		center = 0;
		spread = 0;
		for (int n = 0; n < count; n++) begin
			if (n % GROUP_SIZE == 0) begin
				case ($urandom_range(5))
					0: center = int'(cal_dry);
					1: center = int'(cal_wet);
					2: center = int'(lim_low);
					3: center = int'(lim_high);
					default: center = int'($urandom_range(ADC_MAX));
				endcase
				center += int'($urandom_range(4)) - 2;
				spread = ($urandom_range(2) == 0) ? 0 : 1 << $urandom_range(8);
			end
			case ($urandom_range(15))
				0: value = int'($urandom_range(ADC_MAX));
				1: value = $urandom_range(1) ? ADC_MAX : 0;
				default: value = center + int'($urandom_range(2 * spread)) - spread;
			endcase
			if (value < 0)
				value = 0;
			if (value > ADC_MAX)
				value = ADC_MAX;
			send_sample(count_t'(value));
		end
	endtask

	// With the reset calibration: an all-zero group reads invalid at the low end,
	// an all-ones group invalid at the high end, and a mid-range group checks the
	// truncation of the mean.
	task automatic test_reset_defaults();
		repeat (GROUP_SIZE)
			send_sample('0);
		repeat (GROUP_SIZE)
			send_sample('1);
		repeat (GROUP_SIZE - 1)
			send_sample(count_t'(2100));
		send_sample(count_t'(2107));
		settle_readings();
	endtask

	// Calibration corners: full-scale dry and wet counts in both directions, equal
	// counts, wet above dry with clamping at both ends, a low limit above or equal
	// to the high limit, and a one-count span that overflows the percentage.
	task automatic test_calibration_corners();
		load_calibration(count_t'(ADC_MAX), '0, '0, count_t'(ADC_MAX));
		run_samples(48);
		settle_readings();
		load_calibration('0, count_t'(ADC_MAX), '0, count_t'(ADC_MAX));
		run_samples(48);
		settle_readings();
		load_calibration(count_t'(2000), count_t'(2000), count_t'(10), count_t'(4085));
		run_samples(48);
		settle_readings();
		load_calibration(count_t'(1000), count_t'(3000), count_t'(500), count_t'(3500));
		run_samples(48);
		settle_readings();
		load_calibration(count_t'(3000), count_t'(1200), count_t'(3000), count_t'(1000));
		run_samples(48);
		settle_readings();
		load_calibration(count_t'(3000), count_t'(1200), count_t'(2048), count_t'(2048));
		run_samples(48);
		settle_readings();
		load_calibration(count_t'(3000), count_t'(2999), '0, count_t'(ADC_MAX));
		run_samples(48);
		settle_readings();
	endtask

	// Random calibrations, now and then with equal counts or crossed limits. The
	// sample counts are often not multiples of eight, so groups can straddle the writes.
	task automatic test_random_calibration();
		count_t dry;
		count_t wet;
		count_t low;
		count_t high;
		for (int p = 0; p < 6; p++) begin
			dry = count_t'($urandom_range(ADC_MAX));
			wet = ($urandom_range(4) == 0) ? dry : count_t'($urandom_range(ADC_MAX));
			low = count_t'($urandom_range(300));
			high = count_t'(ADC_MAX - int'($urandom_range(300)));
			if ($urandom_range(5) == 0) begin
				low = count_t'($urandom_range(ADC_MAX));
				high = count_t'($urandom_range(ADC_MAX));
			end
			load_calibration(dry, wet, low, high);
			run_samples(40 + int'($urandom_range(40)));
			settle_readings();
		end
	endtask

	// A long stretch with neither gaps nor stalls, so samples arrive back to back
	// while the block is not busy and finished readings are taken as soon as they appear.
	task automatic test_back_to_back();
		sender_gaps = 1'b0;
		reader_stalls = 1'b0;
		load_calibration(count_t'(3000), count_t'(1200), count_t'(10), count_t'(4085));
		run_samples(200);
		settle_readings();
		sender_gaps = 1'b1;
		reader_stalls = 1'b1;
	endtask

	// The sender holds back after each group until its reading has come out.
	task automatic test_pause_for_readings();
		load_calibration(count_t'(2500), count_t'(900), count_t'(100), count_t'(4000));
		for (int g = 0; g < 4; g++) begin
			run_samples(GROUP_SIZE);
			settle_readings();
		end
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_calibration_corners();
		test_random_calibration();
		test_back_to_back();
		test_pause_for_readings();
		if (mismatches == 0) begin
			$display("moisture_average_and_scale test passed");
		end else begin
			$display("moisture_average_and_scale test failed");
		end
		$finish;
	end

endmodule
